@@ design/matrix_multiply_defines.svh @@
// Assertion macros for the matrix multiply block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS

// Check gated off while reset is asserted.
`define MM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check that also holds through reset.
`define MM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MM_ASSERT(lbl, clk, rst_n, prop, msg)
`define MM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ design/mm_pkg.sv @@
// Shared constants, types and helpers for the matrix multiply block.
// Used by mm_ctrl, mm_datapath and matrix_multiply; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths
    localparam int VALUE_W   = 32;
    localparam int ROWCOL_W  = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;
    localparam logic [CFG_W-1:0]     CFG_RESET  = 4'd8;

    // Derived widths
    localparam int DIMC_W    = $clog2(MAX_DIM + 1);
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W     = $clog2(2 * MEM_DEPTH + 1);
    localparam int ACC_W     = 2 * DATA_WIDTH + $clog2(MAX_DIM);
    localparam int OUT_TDATA_W = ((VALUE_W + 2 * ROWCOL_W + 7) / 8) * 8;

    // Controller to datapath
    typedef struct packed {
        logic              wr_en;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic              rd_first;
        logic              rd_last;
        logic [ADDR_W-1:0] rd_a_addr;
        logic [ADDR_W-1:0] rd_b_addr;
        logic              out_load;
        logic [ROWCOL_W-1:0] out_row;
        logic [ROWCOL_W-1:0] out_col;
        logic              out_last;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic acc_done;
        logic out_free;
    } t_dp_sts;

    // Size register to effective dimension: 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic logic [DIMC_W-1:0] dim_clamp(input logic [CFG_W-1:0] raw);
        logic [DIMC_W-1:0] d;
        if (raw == '0) begin
            d = DIMC_W'(1);
        end else if (int'(raw) > MAX_DIM) begin
            d = DIMC_W'(MAX_DIM);
        end else begin
            d = DIMC_W'(raw);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ design/mm_ctrl.sv @@
// Controller: size registers, load counting, MAC sequencing and result hand-off.
// Depends on mm_pkg and matrix_multiply_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_multiply_defines.svh"

module mm_ctrl
    import mm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_dp_cmd                   o_cmd,
    input  t_dp_sts                   i_sts
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_rows_a, r_inner, r_cols_b;
    logic [CNT_W-1:0]  r_load_cnt, n_load_cnt;
    logic [IDX_W-1:0]  r_i, n_i, r_j, n_j, r_k, n_k;
    logic [ADDR_W-1:0] r_a_base, n_a_base, r_a_addr, n_a_addr, r_b_addr, n_b_addr;

    logic [DIMC_W-1:0] w_nr, w_ni, w_nc;
    logic [CNT_W-1:0]  w_na, w_total, w_b_off;
    logic              w_cfg_wr, w_cfg_hit, w_in_acc;
    logic              w_k_last, w_j_last, w_i_last;

    assign w_nr    = dim_clamp(r_rows_a);
    assign w_ni    = dim_clamp(r_inner);
    assign w_nc    = dim_clamp(r_cols_b);
    assign w_na    = CNT_W'(w_nr) * CNT_W'(w_ni);
    assign w_total = w_na + CNT_W'(w_ni) * CNT_W'(w_nc);
    assign w_b_off = r_load_cnt - w_na;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_cfg_hit   = w_cfg_wr && (i_cfg_index == REG_ROWS_A || i_cfg_index == REG_INNER ||
                                      i_cfg_index == REG_COLS_B);

    assign o_s_tready = (r_state == ST_LOAD);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    assign w_k_last = (DIMC_W'(r_k) + DIMC_W'(1)) == w_ni;
    assign w_j_last = (DIMC_W'(r_j) + DIMC_W'(1)) == w_nc;
    assign w_i_last = (DIMC_W'(r_i) + DIMC_W'(1)) == w_nr;

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_a_base   = r_a_base;
        n_a_addr   = r_a_addr;
        n_b_addr   = r_b_addr;
        o_cmd      = '0;
        o_cmd.rd_a_addr = r_a_addr;
        o_cmd.rd_b_addr = r_b_addr;
        o_cmd.out_row   = ROWCOL_W'(r_i);
        o_cmd.out_col   = ROWCOL_W'(r_j);
        o_cmd.out_last  = w_i_last && w_j_last;

        case (r_state)
            ST_LOAD: begin
                o_cmd.wr_b    = (r_load_cnt >= w_na);
                o_cmd.wr_addr = o_cmd.wr_b ? w_b_off[ADDR_W-1:0] : r_load_cnt[ADDR_W-1:0];
                if (w_in_acc) begin
                    o_cmd.wr_en = 1'b1;
                    if (r_load_cnt + CNT_W'(1) == w_total) begin
                        n_load_cnt = '0;
                        n_state    = ST_MAC;
                        n_i        = '0;
                        n_j        = '0;
                        n_k        = '0;
                        n_a_base   = '0;
                        n_a_addr   = '0;
                        n_b_addr   = '0;
                    end else begin
                        n_load_cnt = r_load_cnt + CNT_W'(1);
                    end
                end
            end
            ST_MAC: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = (r_k == '0);
                o_cmd.rd_last  = w_k_last;
                if (w_k_last) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k      = r_k + IDX_W'(1);
                    n_a_addr = r_a_addr + ADDR_W'(1);
                    n_b_addr = r_b_addr + ADDR_W'(w_nc);
                end
            end
            ST_WAIT: begin
                if (i_sts.acc_done && i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (w_i_last && w_j_last) begin
                        n_state = ST_LOAD;
                    end else if (w_j_last) begin
                        n_j      = '0;
                        n_i      = r_i + IDX_W'(1);
                        n_a_base = r_a_base + ADDR_W'(w_ni);
                        n_a_addr = r_a_base + ADDR_W'(w_ni);
                        n_b_addr = '0;
                        n_state  = ST_MAC;
                    end else begin
                        n_j      = r_j + IDX_W'(1);
                        n_a_addr = r_a_base;
                        n_b_addr = ADDR_W'(r_j) + ADDR_W'(1);
                        n_state  = ST_MAC;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // a size write aborts a partial load
        if (w_cfg_hit) begin
            n_load_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_rows_a   <= CFG_RESET;
            r_inner    <= CFG_RESET;
            r_cols_b   <= CFG_RESET;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    REG_ROWS_A: r_rows_a <= i_cfg_data;
                    REG_INNER:  r_inner  <= i_cfg_data;
                    REG_COLS_B: r_cols_b <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_a_base <= n_a_base;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
    end

    `MM_ASSERT(a_mac_k_range, i_clk, i_rst_n, (r_state == ST_MAC) |-> (DIMC_W'(r_k) < w_ni), "k beyond inner dimension")
    `MM_ASSERT(a_out_load_ok, i_clk, i_rst_n, o_cmd.out_load |-> (i_sts.acc_done && i_sts.out_free), "result loaded before it was ready")
    `MM_ASSERT(a_last_to_load, i_clk, i_rst_n, (o_cmd.out_load && o_cmd.out_last) |=> (r_state == ST_LOAD && r_load_cnt == '0), "final element did not return to load")

endmodule

`default_nettype wire

@@ design/mm_datapath.sv @@
// Datapath: A/B element memories, multiplier, wide accumulator, saturation and
// output register. Depends on mm_pkg and matrix_multiply_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_multiply_defines.svh"

module mm_datapath
    import mm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  wire logic [DATA_WIDTH-1:0] i_wr_data,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_m_tready,
    output logic                       o_out_valid,
    output logic [VALUE_W-1:0]         o_out_product,
    output logic [ROWCOL_W-1:0]        o_out_row,
    output logic [ROWCOL_W-1:0]        o_out_col,
    output logic                       o_out_last
);

    logic [DATA_WIDTH-1:0] r_a_mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] r_b_mem [MEM_DEPTH];

    logic signed [DATA_WIDTH-1:0]   r_a_q, r_b_q;
    logic signed [2*DATA_WIDTH-1:0] r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [ACC_W-1:0]        w_shift;
    logic signed [DATA_WIDTH-1:0]   w_sat;
    logic [ACC_W-DATA_WIDTH:0]      w_upper;
    logic r_s1_valid, r_s1_first, r_s1_last;
    logic r_s2_valid, r_s2_first, r_s2_last;
    logic r_acc_done, r_out_valid;

    // element memories: one write port, one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            if (i_cmd.wr_b) begin
                r_b_mem[i_cmd.wr_addr] <= i_wr_data;
            end else begin
                r_a_mem[i_cmd.wr_addr] <= i_wr_data;
            end
        end
        r_a_q <= r_a_mem[i_cmd.rd_a_addr];
        r_b_q <= r_b_mem[i_cmd.rd_b_addr];
    end

    // floor(sum / 2^16), then clip to DATA_WIDTH bits
    assign w_shift = r_acc >>> FRAC_W;
    assign w_upper = w_shift[ACC_W-1:DATA_WIDTH-1];
    always_comb begin
        if ((&w_upper) || !(|w_upper)) begin
            w_sat = w_shift[DATA_WIDTH-1:0];
        end else if (w_shift[ACC_W-1]) begin
            w_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_a_q * r_b_q;
        if (r_s2_valid) begin
            r_acc <= r_s2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.out_load) begin
            o_out_product <= VALUE_W'(w_sat);
            o_out_row     <= i_cmd.out_row;
            o_out_col     <= i_cmd.out_col;
            o_out_last    <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_first  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_first  <= 1'b0;
            r_s2_last   <= 1'b0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.rd_en;
            r_s1_first <= i_cmd.rd_first;
            r_s1_last  <= i_cmd.rd_last;
            r_s2_valid <= r_s1_valid;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            if (r_s2_valid && r_s2_last) begin
                r_acc_done <= 1'b1;
            end else if (i_cmd.out_load) begin
                r_acc_done <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.acc_done = r_acc_done;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    `MM_ASSERT(a_pipe_empty_when_done, i_clk, i_rst_n, r_acc_done |-> !r_s1_valid, "MAC still in flight with result pending")
    `MM_ASSERT(a_out_from_load, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(i_cmd.out_load), "output valid without a load")

endmodule

`default_nettype wire

@@ design/matrix_multiply.sv @@
// Loading: one input word per cycle while in the load state. Each C element is computed
//   by the single multiply-accumulate unit (one MAC per cycle while computing an element,
//   3-stage drain: read, multiply, accumulate) and then goes to the output register.
// No input is taken until the final C element of a pair is loaded into the output register.
// Reset: synchronous, active low; sizes return to 8x8x8, load count clears.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply
    import mm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input stream: A elements row-major, then B elements row-major
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
    // result stream: C row-major
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [31:0] product, [34:32] row,
                                                        // [37:35] col, rest zero
    output logic                        m_axis_tlast,   // final element of C
    // size register writes: 0 rows_a, 1 inner, 2 cols_b
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    logic [VALUE_W-1:0]  w_product;
    logic [ROWCOL_W-1:0] w_row, w_col;

    // sequencer: owns sizes, load count and the i/j/k loop
    mm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // storage + MAC + output register; only the low DATA_WIDTH bits of a word count
    mm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_wr_data     (s_axis_tdata[DATA_WIDTH-1:0]),
        .o_sts         (w_sts),
        .i_m_tready    (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_product (w_product),
        .o_out_row     (w_row),
        .o_out_col     (w_col),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - VALUE_W - 2*ROWCOL_W){1'b0}}, w_col, w_row, w_product};

endmodule

`default_nettype wire
